>>> rtl/core/wce_pkg.sv
// Shared types, constants and codes for the waveform column envelope block.
package wce_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SPC_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int HALF_W    = 11;
    localparam int CNT_W     = SPC_W + 1;             // holds a full 65536-sample column
    localparam int MAG_W     = 32;
    localparam int MAX_W     = SAMPLE_W - 1;
    localparam int PSUM_W    = 31;
    localparam int NSUM_W    = 32;
    localparam int MUL_A_W   = MAG_W + GAIN_W;        // magnitude times gain
    localparam int MUL_B_W   = GAIN_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int PROD_W    = MUL_A_W + HALF_W;      // magnitude times gain times half height
    localparam int FRAC_SH   = 23;                    // 256 * 32768
    localparam int REM_W     = PROD_W - FRAC_SH;
    localparam int QUO_W     = HALF_W;
    localparam int BIT_W     = 4;
    localparam int DSH_W     = CNT_W + QUO_W;
    localparam int LOW_W     = HALF_W + 1;
    localparam int HIGH_W    = HALF_W;
    localparam int NUM_FLD   = 4;
    localparam int FLD_W     = 2;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int TDATA_W   = 48;

    localparam logic [SPC_W-1:0]  SPC_RESET  = 16'd441;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
    localparam logic [HALF_W-1:0] HALF_RESET = 11'd64;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_SPC  = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_HALF = 2'd2;

    // result field order inside the scaler
    localparam logic [FLD_W-1:0] FLD_PEAK_LOW  = 2'd0;
    localparam logic [FLD_W-1:0] FLD_PEAK_HIGH = 2'd1;
    localparam logic [FLD_W-1:0] FLD_MEAN_LOW  = 2'd2;
    localparam logic [FLD_W-1:0] FLD_MEAN_HIGH = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_MUL_HALF,
        ST_SAT,
        ST_DIV,
        ST_STORE,
        ST_DONE
    } wce_state_t;

    typedef struct packed {
        logic [SPC_W-1:0]  spc;
        logic [GAIN_W-1:0] gain;
        logic [HALF_W-1:0] half;
    } wce_cfg_t;

    // column snapshot: magnitudes in field order, and the folded count
    typedef struct packed {
        logic [NUM_FLD-1:0][MAG_W-1:0] mag;
        logic [CNT_W-1:0]              n;
    } wce_snap_t;

    typedef struct packed {
        logic idle;
        logic done;
    } wce_status_t;

    typedef struct packed {
        logic signed [LOW_W-1:0] peak_low;
        logic [HIGH_W-1:0]       peak_high;
        logic signed [LOW_W-1:0] mean_low;
        logic [HIGH_W-1:0]       mean_high;
    } wce_result_t;

endpackage

>>> rtl/core/wce_regs.sv
// Configuration register file behind the APB-style port.
module wce_regs
    import wce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output wce_cfg_t          cfg
);

    wce_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spc  <= SPC_RESET;
            cfg_reg.gain <= GAIN_RESET;
            cfg_reg.half <= HALF_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SPC:  cfg_reg.spc  <= pwdata[SPC_W-1:0];
                REG_GAIN: cfg_reg.gain <= pwdata[GAIN_W-1:0];
                REG_HALF: cfg_reg.half <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SPC:  prdata = {{(DATA_W-SPC_W){1'b0}}, cfg_reg.spc};
            REG_GAIN: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain};
            REG_HALF: prdata = {{(DATA_W-HALF_W){1'b0}}, cfg_reg.half};
            default:  prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/wce_accum.sv
// Per-sample column accumulator: count, peaks and signed sums.
module wce_accum
    import wce_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [SPC_W-1:0]           spc,
    output logic                       col_end,
    output wce_snap_t                  snap
);

    logic [SPC_W-1:0]         cnt_reg;
    logic [MAX_W-1:0]         max_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic [PSUM_W-1:0]        psum_reg;
    logic signed [NSUM_W-1:0] nsum_reg;

    logic                       pos;
    logic [CNT_W-1:0]           cnt_v;
    logic [CNT_W-1:0]           len;
    logic [MAX_W-1:0]           max_v;
    logic signed [SAMPLE_W-1:0] min_v;
    logic [PSUM_W-1:0]          psum_v;
    logic signed [NSUM_W-1:0]   nsum_v;

    always_comb begin
        pos    = (sample > 16'sd0);
        cnt_v  = {1'b0, cnt_reg} + CNT_W'(1);
        len    = (spc == '0) ? CNT_W'(1) : {1'b0, spc};
        max_v  = (pos && (sample[MAX_W-1:0] > max_reg)) ? sample[MAX_W-1:0] : max_reg;
        min_v  = (!pos && (sample < min_reg)) ? sample : min_reg;
        psum_v = psum_reg + (pos ? {{(PSUM_W-MAX_W){1'b0}}, sample[MAX_W-1:0]} : '0);
        nsum_v = nsum_reg + (pos ? '0 : {{(NSUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample});
        // a wrapped count (65536 samples) also ends the column
        col_end = (cnt_v >= len);

        snap.mag[FLD_PEAK_LOW]  = MAG_W'(0) - {{(MAG_W-SAMPLE_W){min_v[SAMPLE_W-1]}}, min_v};
        snap.mag[FLD_PEAK_HIGH] = {{(MAG_W-MAX_W){1'b0}}, max_v};
        snap.mag[FLD_MEAN_LOW]  = MAG_W'(0) - nsum_v;
        snap.mag[FLD_MEAN_HIGH] = {{(MAG_W-PSUM_W){1'b0}}, psum_v};
        snap.n                  = cnt_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            max_reg  <= '0;
            min_reg  <= '0;
            psum_reg <= '0;
            nsum_reg <= '0;
        end else if (accept) begin
            if (col_end) begin
                cnt_reg  <= '0;
                max_reg  <= '0;
                min_reg  <= '0;
                psum_reg <= '0;
                nsum_reg <= '0;
            end else begin
                cnt_reg  <= cnt_v[SPC_W-1:0];
                max_reg  <= max_v;
                min_reg  <= min_v;
                psum_reg <= psum_v;
                nsum_reg <= nsum_v;
            end
        end
    end

endmodule

>>> rtl/core/wce_scaler.sv
// Column scaler: one shared multiplier and one shift-subtract divider step under a sequencer.
module wce_scaler
    import wce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  wce_snap_t   snap,
    input  wce_cfg_t    cfg,
    input  logic        ack,
    output wce_status_t status,
    output wce_result_t result
);

    wce_state_t        state_reg, state_next;
    logic [FLD_W-1:0]  fld_reg, fld_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    wce_snap_t         snap_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              sat_reg, sat_next;
    wce_result_t       result_reg, result_next;

    logic [MAG_W-1:0]   mag_sel;
    logic [CNT_W-1:0]   div_sel;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [REM_W-1:0]   rem_op;
    logic [BIT_W-1:0]   shift;
    logic [DSH_W-1:0]   dsh;
    logic [REM_W:0]     diff;
    logic               ge;
    logic [QUO_W-1:0]   qclamp;
    logic [LOW_W-1:0]   qneg;

    // shared datapath
    always_comb begin
        mag_sel = snap_reg.mag[fld_reg];
        div_sel = ((fld_reg == FLD_PEAK_LOW) || (fld_reg == FLD_PEAK_HIGH))
                  ? CNT_W'(1) : snap_reg.n;

        if (state_reg == ST_MUL_GAIN) begin
            mul_a = {{(MUL_A_W-MAG_W){1'b0}}, mag_sel};
            mul_b = cfg.gain;
        end else begin
            mul_a = prod_reg[MUL_A_W-1:0];
            mul_b = {{(MUL_B_W-HALF_W){1'b0}}, cfg.half};
        end
        mul_p = mul_a * mul_b;

        // saturation test uses the same subtractor at shift QUO_W
        rem_op = (state_reg == ST_SAT) ? prod_reg[PROD_W-1:FRAC_SH] : rem_reg;
        shift  = (state_reg == ST_SAT) ? BIT_W'(QUO_W) : bit_reg;
        dsh    = {{(DSH_W-CNT_W){1'b0}}, div_sel} << shift;
        diff   = {1'b0, rem_op} - {{(REM_W+1-DSH_W){1'b0}}, dsh};
        ge     = !diff[REM_W];

        qclamp = (sat_reg || (quo_reg > cfg.half)) ? cfg.half : quo_reg;
        qneg   = LOW_W'(0) - {1'b0, qclamp};
    end

    always_comb begin
        state_next  = state_reg;
        fld_next    = fld_reg;
        bit_next    = bit_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        sat_next    = sat_reg;
        result_next = result_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    fld_next   = FLD_PEAK_LOW;
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN: begin
                prod_next  = mul_p[PROD_W-1:0];
                state_next = ST_MUL_HALF;
            end
            ST_MUL_HALF: begin
                prod_next  = mul_p[PROD_W-1:0];
                state_next = ST_SAT;
            end
            ST_SAT: begin
                rem_next   = prod_reg[PROD_W-1:FRAC_SH];
                sat_next   = ge;
                quo_next   = '0;
                bit_next   = BIT_W'(QUO_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (ge) begin
                    rem_next          = diff[REM_W-1:0];
                    quo_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0) begin
                    state_next = ST_STORE;
                end else begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_STORE: begin
                unique case (fld_reg)
                    FLD_PEAK_LOW:  result_next.peak_low  = qneg;
                    FLD_PEAK_HIGH: result_next.peak_high = qclamp;
                    FLD_MEAN_LOW:  result_next.mean_low  = qneg;
                    FLD_MEAN_HIGH: result_next.mean_high = qclamp;
                    default: ;
                endcase
                if (fld_reg == FLD_MEAN_HIGH) begin
                    state_next = ST_DONE;
                end else begin
                    fld_next   = fld_reg + FLD_W'(1);
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_DONE: begin
                if (ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && start) begin
            snap_reg <= snap;
        end
        fld_reg    <= fld_next;
        bit_reg    <= bit_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        sat_reg    <= sat_next;
        result_reg <= result_next;
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign result      = result_reg;

endmodule

>>> rtl/core/waveform_column_envelope.sv
// Waveform column envelope: min/max/mean of each sample column, scaled for display.
//
// Input stream (s_*): one signed 16-bit sample per transfer in s_tdata.
// Output stream (m_*): one result per column, packed in m_tdata.
// APB port: samples_per_column at 0x0, amplitude_gain at 0x4, half_height at 0x8;
// write only while the block is idle.
// Samples that do not end a column are taken at one per cycle.
// The sample that ends a column starts the scaler, which runs four values through
// one multiplier (two passes each) and an 11-step shift-subtract divider.
// s_tready is low from that transfer until the result is loaded into the output
// register, which happens once the scaler is done and that register is free.
// If the receiver stalls, the result holds in m_tdata; the scaler then waits with
// the next result and s_tready stays low until the output register frees up.
// Reset (synchronous, active low) restores register defaults (441, 256, 64),
// clears the accumulators and drops m_tvalid.
module waveform_column_envelope
    import wce_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [15:0] sample
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [11:0] peak_low, [22:12] peak_high,
                                          // [34:23] mean_low, [45:35] mean_high
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    wce_cfg_t    cfg;
    wce_snap_t   snap;
    wce_status_t status;
    wce_result_t result;
    logic        s_xfer;
    logic        col_end;
    logic        load;

    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;

    assign s_tready = status.idle;
    assign s_xfer   = s_tvalid && s_tready;
    assign load     = status.done && (!m_tvalid_reg || m_tready);

    wce_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wce_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_xfer),
        .sample  (s_tdata),
        .spc     (cfg.spc),
        .col_end (col_end),
        .snap    (snap)
    );

    wce_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_xfer && col_end),
        .snap    (snap),
        .cfg     (cfg),
        .ack     (load),
        .status  (status),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {2'b00, result.mean_high, result.mean_low,
                            result.peak_high, result.peak_low};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/core/wce_checker.sv
// Port-level checker for the waveform column envelope, bound to the top level.
module wce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // the low fields are never positive
    a_low_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11] || (m_tdata[11:0] == 12'd0))
                  && (m_tdata[34] || (m_tdata[34:23] == 12'd0)))
        else $error("low field positive");

    // the input only closes right after a transfer
    a_busy_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("s_tready dropped without a transfer");

    // a new result comes only at the end of a busy phase
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a column end");

endmodule

bind waveform_column_envelope wce_checker u_wce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/waveform_column_envelope_tb.sv
// Testbench for waveform_column_envelope: directed and random sample streams checked per column.
module waveform_column_envelope_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wce_pkg::*;

    localparam int     DRAIN_CYCLES = 80;
    localparam int     RANDOM_ITEMS = 560;
    localparam longint SCALE_DEN    = 32768;
    localparam longint GAIN_ONE     = 256;      // Q8.8 unity

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;    // [15:0] sample
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // [11:0] peak_low, [22:12] peak_high,
                                    // [34:23] mean_low, [45:35] mean_high
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    bit burst;

    class column_scoreboard;
        logic [SPC_W-1:0]  spc;
        logic [GAIN_W-1:0] gain;
        logic [HALF_W-1:0] half;
        int                count;
        int                run_max;
        int                run_min;
        longint            pos_sum;
        longint            neg_sum;
        wce_result_t       column_q[$];
        int                errors;

        function new();
            spc     = SPC_RESET;
            gain    = GAIN_RESET;
            half    = HALF_RESET;
            count   = 0;
            run_max = 0;
            run_min = 0;
            pos_sum = 0;
            neg_sum = 0;
            errors  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_SPC:  spc  = val[SPC_W-1:0];
                REG_GAIN: gain = val[GAIN_W-1:0];
                REG_HALF: half = val[HALF_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_SPC:  return DATA_W'(spc);
                REG_GAIN: return DATA_W'(gain);
                REG_HALF: return DATA_W'(half);
                default:  return '0;
            endcase
        endfunction

        // acc * gain * half / (256 * div), then / 32768, both truncated toward zero
        function longint scaled(longint acc, longint div);
            longint g;
            longint h;
            longint prod;
            g    = gain;
            h    = half;
            prod = acc * g * h;
            return (prod / (GAIN_ONE * div)) / SCALE_DEN;
        endfunction

        function longint clamped(longint v);
            longint h;
            h = half;
            if (v > h) return h;
            if (v < -h) return -h;
            return v;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] raw);
            int          s;
            int          len;
            longint      n;
            wce_result_t r;
            s   = int'($signed(raw));
            len = (spc == 0) ? 1 : int'(spc);
            if (s > 0) begin
                if (s > run_max) run_max = s;
                pos_sum += s;
            end else begin
                if (s < run_min) run_min = s;
                neg_sum += s;
            end
            count = (count + 1) & 16'hFFFF;
            // column closes once the count reaches or passes the length
            if (count != 0 && count < len) return;
            n = (count == 0) ? 65536 : count;
            r.peak_low  = LOW_W'(clamped(scaled(run_min, 1)));
            r.peak_high = HIGH_W'(clamped(scaled(run_max, 1)));
            r.mean_low  = LOW_W'(clamped(scaled(neg_sum, n)));
            r.mean_high = HIGH_W'(clamped(scaled(pos_sum, n)));
            column_q.insert(column_q.size(), r);
            count   = 0;
            run_max = 0;
            run_min = 0;
            pos_sum = 0;
            neg_sum = 0;
        endfunction

        function void mismatch(string what, longint e, longint a);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, e, a);
        endfunction

        function void check_result(logic [TDATA_W-1:0] d);
            wce_result_t got;
            wce_result_t want;
            got.peak_low  = d[11:0];
            got.peak_high = d[22:12];
            got.mean_low  = d[34:23];
            got.mean_high = d[45:35];
            if (column_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h", $time, d);
                return;
            end
            want = column_q.pop_front();
            if (got.peak_low != want.peak_low)
                mismatch("peak_low", want.peak_low, got.peak_low);
            if (got.peak_high != want.peak_high)
                mismatch("peak_high", want.peak_high, got.peak_high);
            if (got.mean_low != want.mean_low)
                mismatch("mean_low", want.mean_low, got.mean_low);
            if (got.mean_high != want.mean_high)
                mismatch("mean_high", want.mean_high, got.mean_high);
        endfunction

        function int pending();
            return column_q.size();
        endfunction
    endclass

    column_scoreboard sb;

    waveform_column_envelope dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            3:       return SAMPLE_W'($urandom_range(1, 8));
            4:       return SAMPLE_W'(-int'($urandom_range(1, 8)));
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic send_sample(logic [SAMPLE_W-1:0] v, int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(v);
    endtask

    task automatic hold_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic wait_idle();
        hold_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check(logic [1:0] idx);
        logic [DATA_W-1:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != sb.reg_value(idx))
            sb.mismatch("register readback", sb.reg_value(idx), got);
    endtask

    // junk above each register's width must be dropped
    task automatic set_cfg(int spc, int gain, int half);
        wait_idle();
        reg_write(REG_SPC,  ($urandom() << SPC_W)  | spc);
        reg_write(REG_GAIN, ($urandom() << GAIN_W) | gain);
        reg_write(REG_HALF, ($urandom() << HALF_W) | half);
        reg_check(REG_SPC);
        reg_check(REG_GAIN);
        reg_check(REG_HALF);
    endtask

    initial begin : rx_side
        int g;
        m_tready = 1'b0;
        forever begin
            g = pick_gap();
            repeat (g) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int sent;
        int n;
        int spc;
        int gain;
        int half;
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        burst    = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        reg_check(REG_SPC);
        reg_check(REG_GAIN);
        reg_check(REG_HALF);

        // one-sample columns at the sample extremes
        set_cfg(1, 256, 64);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h0000, 1);
        send_sample(16'h0001, 0);
        send_sample(16'hFFFF, 2);
        // zero length behaves as one
        set_cfg(0, 256, 64);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        // full gain and height, clamped
        set_cfg(4, 65535, 2047);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h0064, 0);
        send_sample(16'hFF9C, 0);
        // zero half height
        set_cfg(3, 512, 0);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        send_sample(16'h0005, 0);
        // zero gain
        set_cfg(2, 0, 2047);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8000, 0);
        // length lowered below the count already folded
        set_cfg(8, 300, 100);
        send_sample(16'h1234, 0);
        send_sample(16'h8000, 1);
        send_sample(16'h7FFF, 0);
        send_sample(16'h0000, 0);
        send_sample(16'hEDCC, 0);
        set_cfg(3, 300, 100);
        send_sample(16'h0100, 0);
        // scaling changed mid-column
        set_cfg(4, 256, 2047);
        send_sample(16'h4000, 0);
        send_sample(16'hC000, 0);
        set_cfg(4, 1024, 500);
        send_sample(16'h7FFF, 0);
        send_sample(16'h8001, 0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       spc = 0;
                1:       spc = 1;
                9:       spc = $urandom_range(13, 60);
                default: spc = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       gain = 0;
                1:       gain = 65535;
                2:       gain = 256;
                default: gain = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 9))
                0:       half = 0;
                1:       half = 1;
                2:       half = 2047;
                default: half = $urandom_range(1, 2047);
            endcase
            set_cfg(spc, gain, half);
            burst = ($urandom_range(0, 3) == 0);
            n     = $urandom_range(15, 60);
            repeat (n) begin
                send_sample(rand_sample(), burst ? 0 : pick_gap());
                if ($urandom_range(0, 79) == 0) hold_for_results();
                sent++;
            end
        end

        // flush the partial column, then two long columns at full scale
        set_cfg(1, 256, 2047);
        send_sample(16'h0000, 0);
        set_cfg(64, 65535, 2047);
        repeat (64) send_sample(16'h7FFF, 0);
        repeat (64) send_sample(16'h8000, 0);

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/wce_pkg.sv
rtl/core/wce_regs.sv
rtl/core/wce_accum.sv
rtl/core/wce_scaler.sv
rtl/core/waveform_column_envelope.sv
rtl/core/wce_checker.sv
tb/waveform_column_envelope_tb.sv
